// ----- hw/rtl/pmpg_pkg.sv -----
// Shared types, register indexes and fixed-point helpers for the power meter
// page generator. No dependencies; every other file imports this package.
package pmpg_pkg;

   localparam int SLOTS_PER_CYCLE = 64;
   localparam int SLOT_W          = $clog2(SLOTS_PER_CYCLE);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_W      = 40;
   localparam int RSP_W      = 64;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] REG_BASE_POWER      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_VARY_ENABLE     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_SERIAL_NUMBER   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_MANUFACTURER_ID = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_MODEL_NUMBER    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_POWER_PAGE_ID   = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_MANU_PAGE_ID    = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_PRODUCT_PAGE_ID = 3'd7;

   localparam logic [7:0] POWER_PAGE_RESET   = 8'd16;
   localparam logic [7:0] MANU_PAGE_RESET    = 8'd80;
   localparam logic [7:0] PRODUCT_PAGE_RESET = 8'd81;

   localparam logic [7:0] BYTE_FILL   = 8'hFF;
   localparam logic [7:0] COMMON_REV  = 8'h01;
   localparam logic [31:0] ADJUST_GAP_MS = 32'd1000;

   // Reciprocal constants; each is exact over the operand range it is used on.
   localparam logic [17:0] RECIP_100 = 18'd167773;  // 2^24 / 100, rounded up
   localparam logic [17:0] RECIP_25  = 18'd167773;  // 2^22 / 25, rounded up
   localparam logic [18:0] RECIP_5   = 19'd419431;  // 2^21 / 5, rounded up
   localparam logic [17:0] CEIL_100  = 18'd99;

   typedef struct packed {
      logic        base_load;
      logic [15:0] base_value;
      logic        vary_enable;
      logic [31:0] serial_number;
      logic [15:0] manufacturer_id;
      logic [15:0] model_number;
      logic [7:0]  power_page_id;
      logic [7:0]  manu_page_id;
      logic [7:0]  product_page_id;
      logic [15:0] bound_hi;
      logic [15:0] bound_lo;
   } cfg_type;

   typedef struct packed {
      logic [7:0] byte7;
      logic [7:0] byte6;
      logic [7:0] byte5;
      logic [7:0] byte4;
      logic [7:0] byte3;
      logic [7:0] byte2;
      logic [7:0] byte1;
      logic [7:0] byte0;
   } page_type;

   // floor(base * 1105 / 1000) saturated to 16 bits, computed as
   // base + floor(floor(base * 21 / 8) / 25).
   function automatic logic [15:0] bound_high(input logic [15:0] base);
      logic [20:0] times21;
      logic [35:0] prod;
      logic [16:0] sum;
      times21 = 21'(base) * 21'd21;
      prod    = 36'(times21[20:3]) * 36'(RECIP_25);
      sum     = 17'(base) + 17'(prod[35:22]);
      bound_high = sum[16] ? 16'hFFFF : sum[15:0];
   endfunction

   // floor(base * 95 / 100), computed as floor(floor(base * 19 / 4) / 5).
   function automatic logic [15:0] bound_low(input logic [15:0] base);
      logic [20:0] times19;
      logic [37:0] prod;
      times19 = 21'(base) * 21'd19;
      prod    = 38'(times19[20:2]) * 38'(RECIP_5);
      bound_low = prod[36:21];
   endfunction

endpackage

// ----- hw/rtl/power_meter_page_generator.sv -----
// Bicycle power meter page generator: one 8-byte page for every broadcast slot.
// An item enters an input register and its page moves into the result register
// once that register is empty or being read out, so rsp_tvalid rises after the
// item has passed both registers, and one item is taken every cycle as long as
// rsp_tready is high. The rate is set by pmpg_core updating effective power,
// accumulated power and event count together for each slot. A write of the base
// power loads the effective power and the clamp bounds at that same clock edge.
// Uses pmpg_pkg; instantiates pmpg_csr and pmpg_core.
module power_meter_page_generator import pmpg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Bits from low: now_ms[31:0], jitter_percent[34:32], zero fill.
   input  logic [REQ_W-1:0]      req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // Bits from low: page_byte0 .. page_byte7, eight bits each.
   output logic [RSP_W-1:0]      rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;

   pmpg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pmpg_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- hw/rtl/pmpg_csr.sv -----
// Configuration registers of the power meter page generator, including the
// clamp bounds that are worked out when the base power is written. Uses pmpg_pkg.
module pmpg_csr import pmpg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic        vary_ff;
   logic [31:0] serial_ff;
   logic [15:0] manu_ff;
   logic [15:0] model_ff;
   logic [7:0]  power_id_ff;
   logic [7:0]  manu_id_ff;
   logic [7:0]  product_id_ff;
   logic [15:0] hi_ff;
   logic [15:0] lo_ff;

   // The base power itself is not kept; only the clamp bounds derived from it are.
   always_ff @(posedge clock) begin
      if (reset) begin
         vary_ff       <= 1'b0;
         serial_ff     <= '0;
         manu_ff       <= '0;
         model_ff      <= '0;
         power_id_ff   <= POWER_PAGE_RESET;
         manu_id_ff    <= MANU_PAGE_RESET;
         product_id_ff <= PRODUCT_PAGE_RESET;
         hi_ff         <= '0;
         lo_ff         <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_BASE_POWER: begin
               hi_ff   <= bound_high(csr_wdata[15:0]);
               lo_ff   <= bound_low(csr_wdata[15:0]);
            end
            REG_VARY_ENABLE:     vary_ff       <= csr_wdata[0];
            REG_SERIAL_NUMBER:   serial_ff     <= csr_wdata;
            REG_MANUFACTURER_ID: manu_ff       <= csr_wdata[15:0];
            REG_MODEL_NUMBER:    model_ff      <= csr_wdata[15:0];
            REG_POWER_PAGE_ID:   power_id_ff   <= csr_wdata[7:0];
            REG_MANU_PAGE_ID:    manu_id_ff    <= csr_wdata[7:0];
            REG_PRODUCT_PAGE_ID: product_id_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.base_load       = csr_we && (csr_addr == REG_BASE_POWER);
      cfg.base_value      = csr_wdata[15:0];
      cfg.vary_enable     = vary_ff;
      cfg.serial_number   = serial_ff;
      cfg.manufacturer_id = manu_ff;
      cfg.model_number    = model_ff;
      cfg.power_page_id   = power_id_ff;
      cfg.manu_page_id    = manu_id_ff;
      cfg.product_page_id = product_id_ff;
      cfg.bound_hi        = hi_ff;
      cfg.bound_lo        = lo_ff;
   end

endmodule

// ----- hw/rtl/pmpg_vary.sv -----
// Percent scaling and clamping of the effective power for one adjustment.
// Purely combinational; uses the reciprocal constants of pmpg_pkg.
module pmpg_vary import pmpg_pkg::*; (
   input  logic              [15:0] effective,
   input  logic signed       [2:0]  jitter,
   input  logic              [15:0] bound_hi,
   input  logic              [15:0] bound_lo,
   output logic              [15:0] adjusted
);

   logic        neg;
   logic [16:0] mag;
   logic [17:0] numer;
   logic [35:0] prod;
   logic [11:0] delta;
   logic [16:0] scaled;

   // e * (100 + j) / 100 = e + floor(e * j / 100), with j limited to -2..2.
   always_comb begin
      neg = jitter[2];
      if (neg) begin
         mag = (jitter == 3'sb111) ? {1'b0, effective} : {effective, 1'b0};
      end else if (jitter[1]) begin
         mag = {effective, 1'b0};
      end else if (jitter[0]) begin
         mag = {1'b0, effective};
      end else begin
         mag = '0;
      end
      // A negative quotient rounds toward minus infinity, so round up the magnitude.
      numer  = neg ? (18'(mag) + CEIL_100) : 18'(mag);
      prod   = 36'(numer) * 36'(RECIP_100);
      delta  = prod[35:24];
      scaled = neg ? (17'(effective) - 17'(delta)) : (17'(effective) + 17'(delta));
      if (scaled > 17'(bound_hi)) begin
         adjusted = bound_hi;
      end else if (scaled < 17'(bound_lo)) begin
         adjusted = bound_lo;
      end else begin
         adjusted = scaled[15:0];
      end
   end

endmodule

// ----- hw/rtl/pmpg_core.sv -----
// Slot pipeline: input register, power/counter state, page assembly and the
// result register. Uses pmpg_pkg and instantiates pmpg_vary.
module pmpg_core import pmpg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   logic              in_valid_ff;
   logic [31:0]       now_ff;
   logic signed [2:0] jit_ff;
   logic [15:0]       eff_ff;
   logic [15:0]       eff_in;
   logic [15:0]       acc_ff;
   logic [15:0]       acc_in;
   logic [7:0]        event_ff;
   logic [7:0]        event_in;
   logic [SLOT_W-1:0] slot_ff;
   logic              manu_next_ff;
   logic [31:0]       last_ff;
   logic              rsp_valid_ff;
   page_type          rsp_ff;
   page_type          rsp_in;
   logic              fire;
   logic              adjust;
   logic [31:0]       elapsed;
   logic [15:0]       adjusted;

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   pmpg_vary u_vary (
      .effective (eff_ff),
      .jitter    (jit_ff),
      .bound_hi  (cfg.bound_hi),
      .bound_lo  (cfg.bound_lo),
      .adjusted  (adjusted)
   );

   always_comb begin
      elapsed  = now_ff - last_ff;
      adjust   = cfg.vary_enable && (elapsed > ADJUST_GAP_MS);
      eff_in   = adjust ? adjusted : eff_ff;
      acc_in   = acc_ff + eff_in;
      event_in = event_ff + 8'd1;
      rsp_in.byte2 = BYTE_FILL;
      if (slot_ff == '0) begin
         rsp_in.byte1 = BYTE_FILL;
         rsp_in.byte3 = COMMON_REV;
         if (manu_next_ff) begin
            rsp_in.byte0 = cfg.manu_page_id;
            rsp_in.byte4 = cfg.manufacturer_id[7:0];
            rsp_in.byte5 = cfg.manufacturer_id[15:8];
            rsp_in.byte6 = cfg.model_number[7:0];
            rsp_in.byte7 = cfg.model_number[15:8];
         end else begin
            rsp_in.byte0 = cfg.product_page_id;
            rsp_in.byte4 = cfg.serial_number[7:0];
            rsp_in.byte5 = cfg.serial_number[15:8];
            rsp_in.byte6 = cfg.serial_number[23:16];
            rsp_in.byte7 = cfg.serial_number[31:24];
         end
      end else begin
         rsp_in.byte0 = cfg.power_page_id;
         rsp_in.byte1 = event_in;
         rsp_in.byte3 = BYTE_FILL;
         rsp_in.byte4 = acc_in[7:0];
         rsp_in.byte5 = acc_in[15:8];
         rsp_in.byte6 = eff_in[7:0];
         rsp_in.byte7 = eff_in[15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         eff_ff       <= '0;
         acc_ff       <= '0;
         event_ff     <= '0;
         slot_ff      <= '0;
         manu_next_ff <= 1'b0;
         last_ff      <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cfg.base_load) begin
            eff_ff <= cfg.base_value;
         end else if (fire) begin
            eff_ff <= eff_in;
         end
         if (fire) begin
            acc_ff   <= acc_in;
            event_ff <= event_in;
            slot_ff  <= (slot_ff == SLOT_W'(SLOTS_PER_CYCLE - 1)) ? '0 : slot_ff + 1'b1;
            if (slot_ff == '0) begin
               manu_next_ff <= !manu_next_ff;
            end
            if (adjust) begin
               last_ff <= now_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         now_ff <= req_tdata[31:0];
         jit_ff <= req_tdata[34:32];
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // An adjusted power always lands inside the clamp window.
   a_eff_in_window: assert property (@(posedge clock) disable iff (reset)
      fire && adjust && !cfg.base_load |=>
         (eff_ff <= $past(cfg.bound_hi)) && (eff_ff >= $past(cfg.bound_lo)))
      else $error("effective power left the clamp window");

   // Each slot advances the event count by exactly one.
   a_event_step: assert property (@(posedge clock) disable iff (reset)
      fire |=> event_ff == $past(event_ff) + 8'd1)
      else $error("event count did not advance by one");

   // Slot zero sends a common page, all other slots a power page.
   a_page_kind: assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_ff.byte3 == COMMON_REV) == ($past(slot_ff) == '0))
      else $error("page kind does not match slot");

   // A waiting item in the input register is never dropped.
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(now_ff) && $stable(jit_ff))
      else $error("pending item lost");

   // Common pages alternate between product and manufacturer.
   a_common_toggle: assert property (@(posedge clock) disable iff (reset)
      fire && slot_ff == '0 |=> manu_next_ff != $past(manu_next_ff))
      else $error("common page did not alternate");

endmodule
